FILE: rtl/servo_et_pkg.sv
package servo_et_pkg;

  localparam int unsigned PosW       = 12;
  localparam int unsigned LoopW      = 20;
  localparam int unsigned TpcW       = 16;
  localparam int unsigned MaxOnW     = 23;
  localparam int unsigned PeriodW    = 26;
  localparam int unsigned CntW       = 27;
  localparam int unsigned BudgetW    = 25;
  localparam int unsigned ProdW      = PosW + TpcW;
  localparam int unsigned SumW       = ProdW + 2;
  localparam int unsigned CfgDataW   = 26;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [LoopW-1:0]   LoopTimeRst  = 20'd10000;
  localparam logic [PosW-1:0]    MinPosRst    = 12'd500;
  localparam logic [PosW-1:0]    MaxPosRst    = 12'd2500;
  localparam logic [TpcW-1:0]    TpcRst       = 16'd8000;
  localparam logic [MaxOnW-1:0]  MaxOnRst     = 23'd5000000;
  localparam logic [PeriodW-1:0] PeriodRst    = 26'd60000000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOOP_TIME      = 3'd0,
    CFG_MIN_POSITION   = 3'd1,
    CFG_MAX_POSITION   = 3'd2,
    CFG_TIME_PER_COUNT = 3'd3,
    CFG_MAX_ON_TIME    = 3'd4,
    CFG_RECHECK_PERIOD = 3'd5
  } cfg_idx_e;

endpackage

FILE: rtl/servo_energize_timeout.sv
// Servo drive with an on-time budget. Each accepted command is one service-loop tick and
// yields exactly one result: the command clamped to the min/max window while the budget is
// positive, else width zero with drive_on_o low. Movement of the command tops the budget up
// by distance times time_per_count, capped at max_on_time; unknown position (after reset and
// once per recheck period) loads the full budget. The block takes one command per clock while
// out_ready_i does not stall it, through an input register, a stage that clamps, forms the
// distance product and advances the recheck counter, and the result register, where the budget
// update closes its loop combinationally. The user must write configuration through cfg_we_i/
// cfg_idx_i/cfg_data_i only while no command is in flight; the block does not enforce this.
module servo_energize_timeout
  import servo_et_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PosW-1:0]     cmd_position_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosW-1:0]     drive_width_o,
  output logic                drive_on_o
);

  // configuration
  logic [LoopW-1:0]   loop_time_q;
  logic [PosW-1:0]    min_pos_q;
  logic [PosW-1:0]    max_pos_q;
  logic [TpcW-1:0]    tpc_q;
  logic [MaxOnW-1:0]  max_on_q;
  logic [PeriodW-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_time_q <= LoopTimeRst;
      min_pos_q   <= MinPosRst;
      max_pos_q   <= MaxPosRst;
      tpc_q       <= TpcRst;
      max_on_q    <= MaxOnRst;
      period_q    <= PeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOOP_TIME:      loop_time_q <= cfg_data_i[LoopW-1:0];
        CFG_MIN_POSITION:   min_pos_q   <= cfg_data_i[PosW-1:0];
        CFG_MAX_POSITION:   max_pos_q   <= cfg_data_i[PosW-1:0];
        CFG_TIME_PER_COUNT: tpc_q       <= cfg_data_i[TpcW-1:0];
        CFG_MAX_ON_TIME:    max_on_q    <= cfg_data_i[MaxOnW-1:0];
        CFG_RECHECK_PERIOD: period_q    <= cfg_data_i[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_adv, s2_adv, out_adv;

  assign out_adv    = s2_valid_q && (!out_valid_q || out_ready_i);
  assign s2_adv     = s1_valid_q && (!s2_valid_q || out_adv);
  assign in_ready_o = !s1_valid_q || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv || out_adv) begin
        s2_valid_q <= s2_adv;
      end
      if (out_adv || out_ready_i) begin
        out_valid_q <= out_adv;
      end
    end
  end

  // stage 1: input register
  logic [PosW-1:0] s1_cmd_q;

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q <= cmd_position_i;
    end
  end

  // stage 1 logic: clamp, distance product, recheck counter
  logic [PosW-1:0]  prev_q;
  logic [CntW-1:0]  cnt_q;
  logic             pos_valid_q;
  logic [PosW-1:0]  clamp_lo, clamp_pos, move_dist;
  logic [ProdW-1:0] prod;
  logic [CntW-1:0]  cnt_sum;
  logic             wrap;

  always_comb begin
    clamp_lo  = (s1_cmd_q < min_pos_q) ? min_pos_q : s1_cmd_q;
    clamp_pos = (clamp_lo > max_pos_q) ? max_pos_q : clamp_lo;
    move_dist = (s1_cmd_q > prev_q) ? (s1_cmd_q - prev_q) : (prev_q - s1_cmd_q);
    prod      = {{TpcW{1'b0}}, move_dist} * {{PosW{1'b0}}, tpc_q};
    cnt_sum   = cnt_q + {{(CntW-LoopW){1'b0}}, loop_time_q};
    wrap      = cnt_sum >= {{(CntW-PeriodW){1'b0}}, period_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      cnt_q       <= '0;
      pos_valid_q <= 1'b0;
    end else if (s2_adv) begin
      prev_q      <= clamp_pos;
      cnt_q       <= wrap ? '0 : cnt_sum;
      pos_valid_q <= 1'b1;
    end
  end

  // stage 2 register
  logic [PosW-1:0]  s2_pos_q;
  logic [ProdW-1:0] s2_prod_q;
  logic             s2_load_q;
  logic             s2_moved_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s2_pos_q   <= clamp_pos;
      s2_prod_q  <= prod;
      s2_load_q  <= wrap || !pos_valid_q;
      s2_moved_q <= s1_cmd_q != prev_q;
    end
  end

  // stage 2 logic: budget update
  logic signed [BudgetW-1:0] budget_q, budget_d, budget_mid;
  logic signed [SumW-1:0]    sum, max_ext, sat;
  logic                      budget_pos;

  always_comb begin
    sum     = {{(SumW-BudgetW){budget_q[BudgetW-1]}}, budget_q}
            + $signed({2'b00, s2_prod_q});
    max_ext = $signed({{(SumW-MaxOnW){1'b0}}, max_on_q});
    sat     = (sum > max_ext) ? max_ext : sum;
    priority if (s2_load_q) begin
      budget_mid = $signed({{(BudgetW-MaxOnW){1'b0}}, max_on_q});
    end else if (s2_moved_q) begin
      budget_mid = sat[BudgetW-1:0];
    end else begin
      budget_mid = budget_q;
    end
    budget_pos = !budget_mid[BudgetW-1] && (budget_mid != '0);
    budget_d   = budget_pos
               ? budget_mid - $signed({{(BudgetW-LoopW){1'b0}}, loop_time_q})
               : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (out_adv) begin
      budget_q <= budget_d;
    end
  end

  // result register
  logic [PosW-1:0] drive_width_q;
  logic            drive_on_q;

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      drive_width_q <= budget_pos ? s2_pos_q : '0;
      drive_on_q    <= budget_pos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_width_o = drive_width_q;
  assign drive_on_o    = drive_on_q;

`ifndef ASSERT_OFF
  a_off_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_on_o |-> drive_width_o == '0)
    else $error("de-energized result carries nonzero width");

  a_off_clears_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv && !budget_pos |=> budget_q == '0)
    else $error("budget not cleared after de-energized tick");

  a_pos_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv |=> pos_valid_q)
    else $error("position not marked known after a tick");
`endif

endmodule

FILE: verif/servo_energize_timeout_test.sv
`timescale 1ns / 1ps

module servo_energize_timeout_test;
  import servo_et_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhaseItems = 230;

  typedef struct packed {
    logic [PosW-1:0] width;
    logic            on;
  } drive_t;

  typedef enum logic {STEP_CMD, STEP_CFG} step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] val;
    logic                typed;
    logic [PosW-1:0]     width;
    logic                on;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [PosW-1:0]     cmd_position_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [PosW-1:0]     drive_width_o;
  logic                drive_on_o;

  // predicted servo state and settings
  logic [LoopW-1:0]   loop_us     = LoopTimeRst;
  logic [PosW-1:0]    min_pos     = MinPosRst;
  logic [PosW-1:0]    max_pos     = MaxPosRst;
  logic [TpcW-1:0]    tpc_us      = TpcRst;
  logic [MaxOnW-1:0]  max_on_us   = MaxOnRst;
  logic [PeriodW-1:0] period_us   = PeriodRst;
  longint             budget_us   = 0;
  logic [CntW-1:0]    recheck_us  = '0;
  logic               pos_known   = 1'b0;
  logic [PosW-1:0]    last_pos    = '0;

  drive_t      drive_q[$];
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;

  localparam int unsigned PlanLen = 32;
  plan_row_t plan [PlanLen] = '{
    '{STEP_CMD, CFG_LOOP_TIME,      26'd0,        1'b1, 12'd500,  1'b1},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b1, 12'd2500, 1'b1},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd1500,     1'b1, 12'd1500, 1'b1},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd1500,     1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_MAX_ON_TIME,    26'd0,        1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd1600,     1'b1, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd1600,     1'b1, 12'd0,    1'b0},
    '{STEP_CFG, CFG_MAX_ON_TIME,    26'h7FFFFF,   1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_LOOP_TIME,      26'd0,        1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd2000,     1'b1, 12'd2000, 1'b1},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd2000,     1'b1, 12'd2000, 1'b1},
    '{STEP_CFG, CFG_MIN_POSITION,   26'd3000,     1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_MAX_POSITION,   26'd1000,     1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd0,        1'b1, 12'd1000, 1'b1},
    '{STEP_CFG, CFG_MIN_POSITION,   26'd0,        1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_MAX_POSITION,   26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b1, 12'd4095, 1'b1},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd0,        1'b1, 12'd0,    1'b1},
    '{STEP_CFG, CFG_TIME_PER_COUNT, 26'd0,        1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_TIME_PER_COUNT, 26'd65535,    1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_LOOP_TIME,      26'h3FFFFFF,  1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_MAX_ON_TIME,    26'd2500000,  1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_RECHECK_PERIOD, 26'd1,        1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_RECHECK_PERIOD, 26'h3FFFFFF,  1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd4095,     1'b0, 12'd0,    1'b0},
    '{STEP_CFG, CFG_MIN_POSITION,   26'h3FFFFFF,  1'b0, 12'd0,    1'b0},
    '{STEP_CMD, CFG_LOOP_TIME,      26'd100,      1'b0, 12'd0,    1'b0}
  };

  servo_energize_timeout DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_position_i(cmd_position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_width_o (drive_width_o),
    .drive_on_o    (drive_on_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic drive_t servo_tick(input logic [PosW-1:0] cmd);
    drive_t          res;
    logic [PosW-1:0] width;
    longint          move_dist;
    recheck_us = recheck_us + CntW'(loop_us);
    if (recheck_us >= CntW'(period_us)) begin
      recheck_us = '0;
      pos_known  = 1'b0;
    end
    if (!pos_known) begin
      budget_us = longint'(max_on_us);
      pos_known = 1'b1;
    end else if (cmd != last_pos) begin
      move_dist = (cmd > last_pos) ? longint'(cmd - last_pos) : longint'(last_pos - cmd);
      budget_us = budget_us + move_dist * longint'(tpc_us);
      if (budget_us > longint'(max_on_us)) begin
        budget_us = longint'(max_on_us);
      end
    end
    width = cmd;
    if (width < min_pos) begin
      width = min_pos;
    end
    if (width > max_pos) begin
      width = max_pos;
    end
    if (budget_us <= 0) begin
      budget_us = 0;
      res = '{'0, 1'b0};
    end else begin
      res = '{width, 1'b1};
      budget_us = budget_us - longint'(loop_us);
    end
    last_pos = width;
    return res;
  endfunction

  function automatic logic [CfgDataW-1:0] stuff_high_bits(input int unsigned v,
                                                          input int unsigned w);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom());
    if (w < CfgDataW && $urandom_range(7) == 0) begin
      return CfgDataW'(v) | (junk << w);
    end
    return CfgDataW'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) begin
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LOOP_TIME: begin
        loop_us = data[LoopW-1:0];
      end
      CFG_MIN_POSITION: begin
        min_pos = data[PosW-1:0];
      end
      CFG_MAX_POSITION: begin
        max_pos = data[PosW-1:0];
      end
      CFG_TIME_PER_COUNT: begin
        tpc_us = data[TpcW-1:0];
      end
      CFG_MAX_ON_TIME: begin
        max_on_us = data[MaxOnW-1:0];
      end
      CFG_RECHECK_PERIOD: begin
        period_us = data[PeriodW-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_cmd(input logic [PosW-1:0] cmd);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_position_i <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    drive_q.push_back(servo_tick(cmd));
  endtask

  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer width %0d on %0b",
                                  drive_width_o, drive_on_o));
      end else begin
        want = drive_q.pop_front();
        if (drive_width_o !== want.width) begin
          report_mismatch($sformatf("drive_width %0d, want %0d", drive_width_o, want.width));
        end
        if (drive_on_o !== want.on) begin
          report_mismatch($sformatf("drive_on %0b, want %0b", drive_on_o, want.on));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned     lp, mo, tpc, per, mn, mx, t;
    logic [PosW-1:0] last_cmd;
    logic [PosW-1:0] next_cmd;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_LOOP_TIME;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    cmd_position_i <= '0;
    out_ready_i    <= 1'b0;
    last_cmd = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_cmd(plan[i].val[PosW-1:0]);
        if (plan[i].typed) begin
          drive_q[drive_q.size()-1] = '{plan[i].width, plan[i].on};
        end
      end
    end

    for (int p = 0; p < Phases; p++) begin
      case ($urandom_range(5))
        0: lp = 0;
        1: lp = 'hFFFFF;
        default: lp = $urandom_range(1, 50000);
      endcase
      case ($urandom_range(5))
        0: mo = 0;
        1: mo = 'h7FFFFF;
        default: mo = lp * $urandom_range(1, 30);
      endcase
      case ($urandom_range(5))
        0: tpc = 0;
        1: tpc = 65535;
        default: tpc = $urandom_range(0, 3000);
      endcase
      case ($urandom_range(5))
        0: per = 1;
        1: per = 'h3FFFFFF;
        default: per = lp * $urandom_range(2, 80);
      endcase
      mn = $urandom_range(2047);
      mx = $urandom_range(2048, 4095);
      case ($urandom_range(3))
        0: begin
          mn = 0;
          mx = 4095;
        end
        1: begin
          t  = mn;
          mn = mx;
          mx = t;
        end
        default: begin
        end
      endcase
      write_reg(CFG_LOOP_TIME, stuff_high_bits(lp, LoopW));
      write_reg(CFG_MIN_POSITION, stuff_high_bits(mn, PosW));
      write_reg(CFG_MAX_POSITION, stuff_high_bits(mx, PosW));
      write_reg(CFG_TIME_PER_COUNT, stuff_high_bits(tpc, TpcW));
      write_reg(CFG_MAX_ON_TIME, stuff_high_bits(mo, MaxOnW));
      write_reg(CFG_RECHECK_PERIOD, stuff_high_bits(per, PeriodW));

      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 66;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 66;
        end
        default: begin
          tx_idle_pct = 7;
          rx_stall_pct <= 7;
        end
      endcase

      // long receiver hold-off while commands keep coming
      if (p == 0) begin
        fork
          begin
            rx_hold <= 1'b1;
            repeat (300) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end

      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(9))
          0, 1, 2: next_cmd = last_cmd;
          3, 4, 5, 6: next_cmd = last_cmd + PosW'($urandom_range(64) - 32);
          default: next_cmd = PosW'($urandom_range(4095));
        endcase
        send_cmd(next_cmd);
        last_cmd = next_cmd;
        if ($urandom_range(149) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/servo_et_pkg.sv
rtl/servo_energize_timeout.sv
verif/servo_energize_timeout_test.sv
